FILE: src/gbn_pkg.sv
// ============================================================================
// gbn_pkg
// Shared types and constants of the go-back-N window sender.
// ============================================================================
package gbn_pkg;

    localparam int WINDOW_FRAMES = 8;
    localparam int MAX_CHUNK     = 1400;

    localparam int OFF_W   = 32;
    localparam int LEN_W   = 11;
    localparam int TICK_W  = 16;
    localparam int RETRY_W = 8;
    localparam int KIND_W  = 3;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 2;
    localparam int SPAN_W  = OFF_W + 3;

    localparam logic [OFF_W-1:0]   TOTAL_RST   = '0;
    localparam logic [LEN_W-1:0]   CHUNK_RST   = LEN_W'(512);
    localparam logic [TICK_W-1:0]  TIMEOUT_RST = TICK_W'(1000);
    localparam logic [RETRY_W-1:0] RETRIES_RST = RETRY_W'(8);

    typedef enum logic [IDX_W-1:0] {
        REG_TOTAL   = 2'd0,
        REG_CHUNK   = 2'd1,
        REG_TIMEOUT = 2'd2,
        REG_RETRIES = 2'd3
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_START  = 2'd0,
        MODE_ACK    = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_CANCEL = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_FRAME    = 3'd0,
        KIND_PROGRESS = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_FAIL     = 3'd3,
        KIND_CANCEL   = 3'd4,
        KIND_BADCHUNK = 3'd5
    } t_kind;

    // what follows the optional progress result of a burst
    typedef enum logic [2:0] {
        TAIL_NONE   = 3'b001,
        TAIL_FRAMES = 3'b010,
        TAIL_TERM   = 3'b100
    } t_tail;

    typedef struct packed {
        logic [OFF_W-1:0]   total;
        logic [LEN_W-1:0]   chunk;
        logic [TICK_W-1:0]  timeout;
        logic [RETRY_W-1:0] retries;
    } t_cfg;

    typedef struct packed {
        logic             pre;
        t_tail            tail;
        t_kind            term;
        logic [OFF_W-1:0] off;
        logic [OFF_W-1:0] wend;
        logic [LEN_W-1:0] chunk;
    } t_burst;

endpackage

FILE: src/gbn_cfg.sv
// ============================================================================
// gbn_cfg
// Register file behind the APB-style configuration port.
// ============================================================================
module gbn_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gbn_pkg::ADDR_W-1:0] paddr,
    input  logic [gbn_pkg::DATA_W-1:0] pwdata,
    output logic [gbn_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output gbn_pkg::t_cfg              o_cfg
);

    gbn_pkg::t_cfg    r_cfg;
    gbn_pkg::t_reg_idx idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = gbn_pkg::t_reg_idx'(paddr[gbn_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total   <= gbn_pkg::TOTAL_RST;
            r_cfg.chunk   <= gbn_pkg::CHUNK_RST;
            r_cfg.timeout <= gbn_pkg::TIMEOUT_RST;
            r_cfg.retries <= gbn_pkg::RETRIES_RST;
        end else if (wr_en) begin
            unique case (idx)
                gbn_pkg::REG_TOTAL:   r_cfg.total   <= pwdata[gbn_pkg::OFF_W-1:0];
                gbn_pkg::REG_CHUNK:   r_cfg.chunk   <= pwdata[gbn_pkg::LEN_W-1:0];
                gbn_pkg::REG_TIMEOUT: r_cfg.timeout <= pwdata[gbn_pkg::TICK_W-1:0];
                gbn_pkg::REG_RETRIES: r_cfg.retries <= pwdata[gbn_pkg::RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            gbn_pkg::REG_TOTAL:   prdata = gbn_pkg::DATA_W'(r_cfg.total);
            gbn_pkg::REG_CHUNK:   prdata = gbn_pkg::DATA_W'(r_cfg.chunk);
            gbn_pkg::REG_TIMEOUT: prdata = gbn_pkg::DATA_W'(r_cfg.timeout);
            gbn_pkg::REG_RETRIES: prdata = gbn_pkg::DATA_W'(r_cfg.retries);
            default:              prdata = '0;
        endcase
    end

endmodule

FILE: src/gbn_step.sv
// ============================================================================
// gbn_step
// Input register and transfer state; turns one event into a result burst.
// ============================================================================
module gbn_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gbn_pkg::t_cfg             i_cfg,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [gbn_pkg::MODE_W-1:0] i_mode,
    input  logic [gbn_pkg::OFF_W-1:0] i_ack_offset,
    input  logic                      i_emit_ready,
    output logic                      o_load,
    output gbn_pkg::t_burst           o_burst
);

    // input register
    logic                        r_in_valid;
    gbn_pkg::t_mode              r_mode;
    logic [gbn_pkg::OFF_W-1:0]   r_ack;

    // transfer state
    logic                        r_busy,   n_busy;
    logic [gbn_pkg::OFF_W-1:0]   r_wend,   n_wend;
    logic [gbn_pkg::OFF_W-1:0]   r_conf,   n_conf;
    logic [gbn_pkg::RETRY_W-1:0] r_stall,  n_stall;
    logic [gbn_pkg::TICK_W-1:0]  r_timer,  n_timer;
    logic                        r_cancel, n_cancel;

    logic                        proc;
    logic                        accept;
    logic [gbn_pkg::OFF_W-1:0]   c_ack;
    logic [gbn_pkg::OFF_W-1:0]   c_work;
    logic                        cancel_work;
    logic [gbn_pkg::SPAN_W-1:0]  span;
    logic [gbn_pkg::SPAN_W-1:0]  sum;
    logic [gbn_pkg::OFF_W-1:0]   win_end;
    logic                        bad_chunk;
    logic [gbn_pkg::TICK_W-1:0]  timer_inc;
    logic [gbn_pkg::RETRY_W:0]   stall_inc;
    logic                        do_open;
    gbn_pkg::t_burst             burst;

    assign proc       = r_in_valid && i_emit_ready;
    assign o_in_stall = r_in_valid && !i_emit_ready;
    assign accept     = i_in_valid && !o_in_stall;

    // confirmed point after an ack, clamped to the image length
    assign c_ack = (r_ack > r_conf) ? ((r_ack > i_cfg.total) ? i_cfg.total : r_ack) : r_conf;

    always_comb begin
        unique case (r_mode)
            gbn_pkg::MODE_START: begin
                c_work      = '0;
                cancel_work = 1'b0;
            end
            gbn_pkg::MODE_ACK: begin
                c_work      = c_ack;
                cancel_work = r_cancel;
            end
            default: begin
                c_work      = r_conf;
                cancel_work = r_cancel;
            end
        endcase
    end

    assign span      = gbn_pkg::SPAN_W'(i_cfg.chunk) * gbn_pkg::SPAN_W'(gbn_pkg::WINDOW_FRAMES);
    assign sum       = gbn_pkg::SPAN_W'(c_work) + span;
    assign win_end   = (sum > gbn_pkg::SPAN_W'(i_cfg.total)) ? i_cfg.total
                                                             : sum[gbn_pkg::OFF_W-1:0];
    assign bad_chunk = (i_cfg.chunk == '0) ||
                       (i_cfg.chunk > gbn_pkg::LEN_W'(gbn_pkg::MAX_CHUNK));
    assign timer_inc = r_timer + 1'b1;
    assign stall_inc = {1'b0, r_stall} + 1'b1;

    always_comb begin
        n_busy     = r_busy;
        n_wend     = r_wend;
        n_conf     = r_conf;
        n_stall    = r_stall;
        n_timer    = r_timer;
        n_cancel   = r_cancel;
        do_open    = 1'b0;
        burst.pre   = 1'b0;
        burst.tail  = gbn_pkg::TAIL_NONE;
        burst.term  = gbn_pkg::KIND_DONE;
        burst.off   = c_work;
        burst.wend  = win_end;
        burst.chunk = i_cfg.chunk;

        unique case (r_mode)
            gbn_pkg::MODE_START: begin
                if (bad_chunk) begin
                    n_busy     = 1'b0;
                    burst.tail = gbn_pkg::TAIL_TERM;
                    burst.term = gbn_pkg::KIND_BADCHUNK;
                    burst.off  = '0;
                end else begin
                    n_busy   = 1'b1;
                    n_conf   = '0;
                    n_stall  = '0;
                    n_cancel = 1'b0;
                    do_open  = 1'b1;
                end
            end
            gbn_pkg::MODE_ACK: begin
                if (r_busy) begin
                    n_conf = c_ack;
                    if (r_ack > r_conf) begin
                        n_stall = '0;
                    end
                    if (c_ack >= r_wend) begin
                        burst.pre = 1'b1;
                        do_open   = 1'b1;
                    end
                end
            end
            gbn_pkg::MODE_TICK: begin
                if (r_busy) begin
                    n_timer = timer_inc;
                    if (timer_inc >= i_cfg.timeout) begin
                        burst.pre = 1'b1;
                        if (stall_inc > {1'b0, i_cfg.retries}) begin
                            n_busy     = 1'b0;
                            burst.tail = gbn_pkg::TAIL_TERM;
                            burst.term = gbn_pkg::KIND_FAIL;
                        end else begin
                            n_stall = stall_inc[gbn_pkg::RETRY_W-1:0];
                            do_open = 1'b1;
                        end
                    end
                end
            end
            gbn_pkg::MODE_CANCEL: begin
                if (r_busy) begin
                    n_cancel = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_open) begin
            if (c_work >= i_cfg.total) begin
                n_busy     = 1'b0;
                burst.tail = gbn_pkg::TAIL_TERM;
                burst.term = gbn_pkg::KIND_DONE;
            end else if (cancel_work) begin
                n_busy     = 1'b0;
                n_cancel   = 1'b0;
                burst.tail = gbn_pkg::TAIL_TERM;
                burst.term = gbn_pkg::KIND_CANCEL;
            end else begin
                n_wend  = win_end;
                n_timer = '0;
                // a zero chunk written mid-transfer gives an empty window
                if (win_end != c_work) begin
                    burst.tail = gbn_pkg::TAIL_FRAMES;
                end
            end
        end
    end

    assign o_burst = burst;
    assign o_load  = proc && (burst.pre || (burst.tail != gbn_pkg::TAIL_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_busy     <= 1'b0;
            r_wend     <= '0;
            r_conf     <= '0;
            r_stall    <= '0;
            r_timer    <= '0;
            r_cancel   <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_busy   <= n_busy;
                r_wend   <= n_wend;
                r_conf   <= n_conf;
                r_stall  <= n_stall;
                r_timer  <= n_timer;
                r_cancel <= n_cancel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= gbn_pkg::t_mode'(i_mode);
            r_ack  <= i_ack_offset;
        end
    end

endmodule

FILE: src/gbn_emit.sv
// ============================================================================
// gbn_emit
// Walks one result burst into the output register, one result per cycle unless stalled.
// ============================================================================
module gbn_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  gbn_pkg::t_burst            i_burst,
    output logic                       o_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [gbn_pkg::KIND_W-1:0] o_kind,
    output logic [gbn_pkg::OFF_W-1:0]  o_offset,
    output logic [gbn_pkg::LEN_W-1:0]  o_length,
    output logic                       o_last
);

    // burst being walked
    logic                       r_pre;
    gbn_pkg::t_tail             r_tail;
    gbn_pkg::t_kind             r_term;
    logic [gbn_pkg::OFF_W-1:0]  r_off;
    logic [gbn_pkg::OFF_W-1:0]  r_w;
    logic [gbn_pkg::OFF_W-1:0]  r_end;
    logic [gbn_pkg::LEN_W-1:0]  r_chunk;

    // output register
    logic                       r_out_valid;
    gbn_pkg::t_kind             r_kind;
    logic [gbn_pkg::OFF_W-1:0]  r_offset;
    logic [gbn_pkg::LEN_W-1:0]  r_length;
    logic                       r_last;

    logic                       busy;
    logic                       adv;
    logic                       out_free;
    logic [gbn_pkg::OFF_W-1:0]  rem;
    logic                       rem_le;
    gbn_pkg::t_kind             cur_kind;
    logic [gbn_pkg::OFF_W-1:0]  cur_off;
    logic [gbn_pkg::LEN_W-1:0]  cur_len;
    logic                       cur_last;

    assign busy     = r_pre || (r_tail != gbn_pkg::TAIL_NONE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign adv      = busy && out_free;
    assign o_ready  = !busy || (adv && cur_last);

    assign rem    = r_end - r_w;
    assign rem_le = rem <= gbn_pkg::OFF_W'(r_chunk);

    always_comb begin
        priority if (r_pre) begin
            cur_kind = gbn_pkg::KIND_PROGRESS;
            cur_off  = r_off;
            cur_len  = '0;
            cur_last = (r_tail == gbn_pkg::TAIL_NONE);
        end else if (r_tail == gbn_pkg::TAIL_TERM) begin
            cur_kind = r_term;
            cur_off  = r_off;
            cur_len  = '0;
            cur_last = 1'b1;
        end else begin
            cur_kind = gbn_pkg::KIND_FRAME;
            cur_off  = r_w;
            cur_len  = rem_le ? rem[gbn_pkg::LEN_W-1:0] : r_chunk;
            cur_last = rem_le;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre       <= 1'b0;
            r_tail      <= gbn_pkg::TAIL_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_pre  <= i_burst.pre;
                r_tail <= i_burst.tail;
            end else if (adv) begin
                if (r_pre) begin
                    r_pre <= 1'b0;
                end else if (r_tail == gbn_pkg::TAIL_TERM || rem_le) begin
                    r_tail <= gbn_pkg::TAIL_NONE;
                end
            end
            if (out_free) begin
                r_out_valid <= adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_term  <= i_burst.term;
            r_off   <= i_burst.off;
            r_w     <= i_burst.off;
            r_end   <= i_burst.wend;
            r_chunk <= i_burst.chunk;
        end else if (adv && !r_pre) begin
            r_w <= r_w + gbn_pkg::OFF_W'(r_chunk);
        end
        if (adv) begin
            r_kind   <= cur_kind;
            r_offset <= cur_off;
            r_length <= cur_len;
            r_last   <= cur_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_offset    = r_offset;
    assign o_length    = r_length;
    assign o_last      = r_last;

endmodule

FILE: src/go_back_n_window_sender.sv
// ============================================================================
// go_back_n_window_sender
// Sender side of a windowed go-back-N image transfer: frame descriptors,
// progress, retries on timeout and the final status.
// ============================================================================
// Input channel (i_in_valid / o_in_stall) carries events: start, ack with the
// receiver's next expected offset, millisecond tick, cancel request. Output
// channel (o_out_valid / i_out_stall) carries results: frame descriptors,
// progress, done, retry failure, cancelled, bad chunk; o_last marks the final
// result caused by an event. Registers sit on the APB port at 4*index.
// An event is taken into the input register, turned into a result burst in the
// walker's burst registers, and its results leave through the output register.
// Results leave at one per cycle while the output does not stall; a burst holds
// at most 9 results (progress plus a full window of 8 frames). Events that
// cause no result pass at one per cycle while no burst is walking. An event
// waits in the input register while the previous burst is still walking.
// A stalled output holds its result and the walker pauses; the input stalls
// once the input register holds an event the walker cannot yet take.
// Reset clears the transfer state and both channels and puts the registers
// at their defaults (chunk 512, timeout 1000 ticks, 8 retries).
// ============================================================================
module go_back_n_window_sender (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gbn_pkg::ADDR_W-1:0] paddr,
    input  logic [gbn_pkg::DATA_W-1:0] pwdata,
    output logic [gbn_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [gbn_pkg::MODE_W-1:0] i_mode,
    input  logic [gbn_pkg::OFF_W-1:0]  i_ack_offset,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [gbn_pkg::KIND_W-1:0] o_kind,
    output logic [gbn_pkg::OFF_W-1:0]  o_offset,
    output logic [gbn_pkg::LEN_W-1:0]  o_length,
    output logic                       o_last
);

    gbn_pkg::t_cfg   cfg;
    gbn_pkg::t_burst burst;
    logic            load;
    logic            emit_ready;

    gbn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gbn_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_ack_offset (i_ack_offset),
        .i_emit_ready (emit_ready),
        .o_load       (load),
        .o_burst      (burst)
    );

    gbn_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_burst     (burst),
        .o_ready     (emit_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_offset    (o_offset),
        .o_length    (o_length),
        .o_last      (o_last)
    );

endmodule

FILE: src/gbn_checker.sv
// ============================================================================
// gbn_checker
// Port-level checks on the go-back-N window sender's result channel.
// ============================================================================
module gbn_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic [gbn_pkg::KIND_W-1:0] o_kind,
    input  logic [gbn_pkg::OFF_W-1:0]  o_offset,
    input  logic [gbn_pkg::LEN_W-1:0]  o_length,
    input  logic                       o_last
);

    // reset empties the result channel
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_kind) && $stable(o_offset) &&
            $stable(o_length) && $stable(o_last))
        else $error("stalled result changed");

    // only frames carry a length, and a frame is never empty
    a_len_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_kind == gbn_pkg::KIND_FRAME) == (o_length != '0)))
        else $error("length does not match result kind");

    // final status results end their event's burst
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == gbn_pkg::KIND_DONE || o_kind == gbn_pkg::KIND_FAIL ||
                        o_kind == gbn_pkg::KIND_CANCEL ||
                        o_kind == gbn_pkg::KIND_BADCHUNK) |-> o_last)
        else $error("final status not marked last");

endmodule

bind go_back_n_window_sender gbn_checker u_gbn_checker (.*);

FILE: sim/go_back_n_window_sender_tb.sv
// ============================================================================
// go_back_n_window_sender_tb
// Self-checking bench for the go-back-N window sender. Directed corner cases,
// a long receiver hold-off and random transfers with noise are
// checked result by result against a behavioral window tracker.
// ============================================================================
module go_back_n_window_sender_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_EVENTS  = 96;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;
    localparam int MAX_STEPS      = 40;
    localparam int WIDE_W         = gbn_pkg::OFF_W + 2;

    typedef struct packed {
        gbn_pkg::t_kind              kind;
        logic [gbn_pkg::OFF_W-1:0]   offset;
        logic [gbn_pkg::LEN_W-1:0]   length;
        logic                        last;
    } t_result;

    class window_tracker;
        t_result                     due[$];
        int                          errors;
        int                          n_events;
        int                          n_acted;
        int                          n_results;
        int                          kind_seen[8];
        logic [gbn_pkg::OFF_W-1:0]   total;
        logic [gbn_pkg::LEN_W-1:0]   chunk;
        logic [gbn_pkg::TICK_W-1:0]  timeout;
        logic [gbn_pkg::RETRY_W-1:0] retries;
        bit                          busy;
        bit                          cancel_pending;
        logic [gbn_pkg::OFF_W-1:0]   window_end;
        logic [gbn_pkg::OFF_W-1:0]   confirmed;
        int                          stalls;
        int unsigned                 timer;

        function new();
            total          = gbn_pkg::TOTAL_RST;
            chunk          = gbn_pkg::CHUNK_RST;
            timeout        = gbn_pkg::TIMEOUT_RST;
            retries        = gbn_pkg::RETRIES_RST;
            busy           = 1'b0;
            cancel_pending = 1'b0;
            window_end     = '0;
            confirmed      = '0;
            stalls         = 0;
            timer          = 0;
            errors         = 0;
            n_events       = 0;
            n_acted        = 0;
            n_results      = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void set_reg(gbn_pkg::t_reg_idx idx, logic [gbn_pkg::DATA_W-1:0] value);
            case (idx)
                gbn_pkg::REG_TOTAL:   total   = value[gbn_pkg::OFF_W-1:0];
                gbn_pkg::REG_CHUNK:   chunk   = value[gbn_pkg::LEN_W-1:0];
                gbn_pkg::REG_TIMEOUT: timeout = value[gbn_pkg::TICK_W-1:0];
                default:              retries = value[gbn_pkg::RETRY_W-1:0];
            endcase
        endfunction

        function void post(gbn_pkg::t_kind kind, logic [gbn_pkg::OFF_W-1:0] offset,
                           logic [gbn_pkg::LEN_W-1:0] length);
            t_result r;
            r.kind   = kind;
            r.offset = offset;
            r.length = length;
            r.last   = 1'b0;
            due.push_back(r);
        endfunction

        // done, cancel, or frames from the confirmed point up to a full window, clamped to the image
        function void open_window();
            logic [WIDE_W-1:0] stop;
            logic [WIDE_W-1:0] pos;
            logic [WIDE_W-1:0] len;
            int                frames;
            if (confirmed >= total) begin
                busy = 1'b0;
                post(gbn_pkg::KIND_DONE, confirmed, '0);
                return;
            end
            if (cancel_pending) begin
                busy           = 1'b0;
                cancel_pending = 1'b0;
                post(gbn_pkg::KIND_CANCEL, confirmed, '0);
                return;
            end
            stop = WIDE_W'(confirmed) + WIDE_W'(gbn_pkg::WINDOW_FRAMES) * WIDE_W'(chunk);
            if (stop > WIDE_W'(total)) stop = WIDE_W'(total);
            window_end = stop[gbn_pkg::OFF_W-1:0];
            timer      = 0;
            frames     = 0;
            pos        = WIDE_W'(confirmed);
            while (pos < stop && frames < gbn_pkg::WINDOW_FRAMES) begin
                len = stop - pos;
                if (len > WIDE_W'(chunk)) len = WIDE_W'(chunk);
                post(gbn_pkg::KIND_FRAME, pos[gbn_pkg::OFF_W-1:0], len[gbn_pkg::LEN_W-1:0]);
                pos    = pos + WIDE_W'(chunk);
                frames = frames + 1;
            end
        endfunction

        function void apply_event(gbn_pkg::t_mode mode, logic [gbn_pkg::OFF_W-1:0] ack);
            int      due_before;
            t_result tail;
            due_before = due.size();
            n_events++;
            if (mode == gbn_pkg::MODE_START || busy) n_acted++;
            case (mode)
                gbn_pkg::MODE_START: begin
                    if (chunk == 0 || chunk > gbn_pkg::MAX_CHUNK) begin
                        busy = 1'b0;
                        post(gbn_pkg::KIND_BADCHUNK, '0, '0);
                    end else begin
                        busy           = 1'b1;
                        confirmed      = '0;
                        stalls         = 0;
                        cancel_pending = 1'b0;
                        open_window();
                    end
                end
                gbn_pkg::MODE_ACK: if (busy) begin
                    if (ack > confirmed) begin
                        confirmed = (ack > total) ? total : ack;
                        stalls    = 0;
                    end
                    if (confirmed >= window_end) begin
                        post(gbn_pkg::KIND_PROGRESS, confirmed, '0);
                        open_window();
                    end
                end
                gbn_pkg::MODE_TICK: if (busy) begin
                    timer++;
                    // a zero timeout behaves as one tick
                    if (timer >= timeout) begin
                        post(gbn_pkg::KIND_PROGRESS, confirmed, '0);
                        if (stalls + 1 > int'(retries)) begin
                            busy = 1'b0;
                            post(gbn_pkg::KIND_FAIL, confirmed, '0);
                        end else begin
                            stalls = stalls + 1;
                            open_window();
                        end
                    end
                end
                gbn_pkg::MODE_CANCEL: if (busy) begin
                    cancel_pending = 1'b1;
                end
            endcase
            if (due.size() > due_before) begin
                tail      = due.pop_back();
                tail.last = 1'b1;
                due.push_back(tail);
            end
        endfunction

        function void compare(string name, logic [gbn_pkg::OFF_W-1:0] want,
                              logic [gbn_pkg::OFF_W-1:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(logic [gbn_pkg::KIND_W-1:0] kind,
                                   logic [gbn_pkg::OFF_W-1:0] offset,
                                   logic [gbn_pkg::LEN_W-1:0] length, logic last);
            t_result want;
            n_results++;
            if (!$isunknown(kind)) kind_seen[kind]++;
            if (due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: unexpected result, expected none, ",
                              "actual kind %0d offset %0d length %0d last %0d"},
                             $time, kind, offset, length, last);
                return;
            end
            want = due.pop_front();
            compare("kind", gbn_pkg::OFF_W'(want.kind), gbn_pkg::OFF_W'(kind));
            compare("offset", want.offset, offset);
            compare("length", gbn_pkg::OFF_W'(want.length), gbn_pkg::OFF_W'(length));
            compare("last", gbn_pkg::OFF_W'(want.last), gbn_pkg::OFF_W'(last));
        endfunction
    endclass

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [gbn_pkg::ADDR_W-1:0]  paddr        = '0;
    logic [gbn_pkg::DATA_W-1:0]  pwdata       = '0;
    logic [gbn_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_stall;
    logic [gbn_pkg::MODE_W-1:0]  i_mode       = '0;
    logic [gbn_pkg::OFF_W-1:0]   i_ack_offset = '0;
    logic                        o_out_valid;
    logic                        i_out_stall  = 1'b0;
    logic [gbn_pkg::KIND_W-1:0]  o_kind;
    logic [gbn_pkg::OFF_W-1:0]   o_offset;
    logic [gbn_pkg::LEN_W-1:0]   o_length;
    logic                        o_last;

    window_tracker tracker;
    bit            calm         = 1'b0;
    bit            hold_request = 1'b0;
    int            quiet_cycles = 0;

    go_back_n_window_sender dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    // receiver side: random stall runs, or one long hold-off on request
    initial begin : rx_stall
        int hold;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                hold = LONG_HOLD;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 2) == 0);
                hold = pick_gap() + 1;
            end
            repeat (hold) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(o_kind, o_offset, o_length, o_last);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(input gbn_pkg::t_mode mode, input logic [gbn_pkg::OFF_W-1:0] ack);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_ack_offset <= ack;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        tracker.apply_event(mode, ack);
    endtask

    // wait for every expected result, then let an event without results drain
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input gbn_pkg::t_reg_idx idx,
                             input logic [gbn_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= gbn_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [gbn_pkg::DATA_W-1:0] total,
                             input logic [gbn_pkg::DATA_W-1:0] chunk,
                             input logic [gbn_pkg::DATA_W-1:0] timeout,
                             input logic [gbn_pkg::DATA_W-1:0] retries);
        write_reg(gbn_pkg::REG_TOTAL, total);
        write_reg(gbn_pkg::REG_CHUNK, chunk);
        write_reg(gbn_pkg::REG_TIMEOUT, timeout);
        write_reg(gbn_pkg::REG_RETRIES, retries);
    endtask

    // one transfer: random settings, a start, then mostly sensible acks and ticks
    task automatic run_transfer();
        logic [gbn_pkg::LEN_W-1:0]   chunk;
        logic [gbn_pkg::OFF_W-1:0]   total;
        logic [gbn_pkg::TICK_W-1:0]  timeout;
        logic [gbn_pkg::RETRY_W-1:0] retries;
        logic [gbn_pkg::OFF_W-1:0]   ack;
        logic [gbn_pkg::OFF_W-1:0]   span;
        gbn_pkg::t_mode              mode;
        int                          r;
        int                          k;
        settle();
        r = $urandom_range(0, 99);
        if (r < 3)       chunk = '0;
        else if (r < 7)  chunk = gbn_pkg::LEN_W'($urandom_range(gbn_pkg::MAX_CHUNK + 1, 2047));
        else if (r < 25) chunk = gbn_pkg::LEN_W'($urandom_range(1, 8));
        else             chunk = gbn_pkg::LEN_W'($urandom_range(1, gbn_pkg::MAX_CHUNK));
        r = $urandom_range(0, 99);
        if (r < 8)                       total = '0;
        else if (r < 88 && chunk != 0)   total = $urandom_range(1, 24 * int'(chunk));
        else                             total = $urandom;
        r = $urandom_range(0, 99);
        if (r < 20)      timeout = '0;
        else if (r < 75) timeout = gbn_pkg::TICK_W'($urandom_range(1, 3));
        else if (r < 95) timeout = gbn_pkg::TICK_W'($urandom_range(4, 12));
        else             timeout = gbn_pkg::TICK_W'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 45)      retries = gbn_pkg::RETRY_W'($urandom_range(0, 3));
        else if (r < 85) retries = gbn_pkg::RETRY_W'($urandom_range(0, 255));
        else             retries = '1;
        configure(total, {21'($urandom), chunk}, {16'($urandom), timeout},
                  {24'($urandom), retries});
        calm = ($urandom_range(0, 4) == 0);
        send(gbn_pkg::MODE_START, $urandom);
        for (k = 0; k < MAX_STEPS && tracker.busy; k++) begin
            r    = $urandom_range(0, 99);
            span = (tracker.window_end > tracker.confirmed) ?
                   tracker.window_end - tracker.confirmed : '0;
            mode = gbn_pkg::MODE_ACK;
            ack  = $urandom;
            if (r < 25 && span != 0) begin
                ack = tracker.window_end;
            end else if (r < 50 && span != 0) begin
                ack = tracker.confirmed + $urandom_range(1, span);
            end else if (r < 55) begin
                // may run past the window or the image
                ack = tracker.confirmed + $urandom_range(1, 3 * span + 1);
            end else if (r < 80) begin
                mode = gbn_pkg::MODE_TICK;
            end else if (r < 85) begin
                mode = gbn_pkg::MODE_CANCEL;
            end else if (r < 91) begin
                ack = $urandom_range(0, tracker.confirmed);
            end else if (r < 95) begin
                ack = $urandom;
            end else if (r < 97) begin
                // new timeout and retry settings in the middle of a transfer
                settle();
                write_reg(gbn_pkg::REG_TIMEOUT, gbn_pkg::DATA_W'($urandom_range(0, 4)));
                write_reg(gbn_pkg::REG_RETRIES, gbn_pkg::DATA_W'($urandom_range(0, 4)));
                mode = gbn_pkg::MODE_TICK;
            end else begin
                mode = gbn_pkg::MODE_START;
            end
            send(mode, ack);
        end
        calm = 1'b0;
    endtask

    initial begin : stimulus
        int mark;
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // events while idle are dropped, then an empty image is done at once
        send(gbn_pkg::MODE_ACK, '1);
        send(gbn_pkg::MODE_TICK, '0);
        send(gbn_pkg::MODE_CANCEL, '0);
        send(gbn_pkg::MODE_START, '0);

        // chunk sizes out of range
        settle();
        write_reg(gbn_pkg::REG_CHUNK, '0);
        send(gbn_pkg::MODE_START, '0);
        settle();
        write_reg(gbn_pkg::REG_CHUNK, '1);
        send(gbn_pkg::MODE_START, '1);
        settle();
        write_reg(gbn_pkg::REG_CHUNK, gbn_pkg::DATA_W'(gbn_pkg::MAX_CHUNK + 1));
        send(gbn_pkg::MODE_START, '0);

        // widest frames, largest image; zero timeout with no retries fails at once
        settle();
        configure('1, gbn_pkg::DATA_W'(gbn_pkg::MAX_CHUNK), '0, '0);
        send(gbn_pkg::MODE_START, '0);
        send(gbn_pkg::MODE_TICK, '0);
        send(gbn_pkg::MODE_ACK, 32'd5);

        // one-byte frames, stale and partial acks, an ack past the image
        settle();
        configure(32'd5, 32'd1, 32'h0000_ffff, 32'd255);
        send(gbn_pkg::MODE_START, '0);
        send(gbn_pkg::MODE_ACK, '0);
        send(gbn_pkg::MODE_ACK, 32'd3);
        send(gbn_pkg::MODE_TICK, '0);
        send(gbn_pkg::MODE_ACK, '1);

        // restart while busy, cancel at the next window, resend, retry limit
        settle();
        configure(32'd100000, 32'd100, 32'd2, 32'd1);
        send(gbn_pkg::MODE_START, '0);
        send(gbn_pkg::MODE_START, '0);
        send(gbn_pkg::MODE_CANCEL, '0);
        send(gbn_pkg::MODE_ACK, 32'd800);
        send(gbn_pkg::MODE_START, '0);
        send(gbn_pkg::MODE_TICK, '0);
        send(gbn_pkg::MODE_TICK, '0);
        send(gbn_pkg::MODE_ACK, 32'd50);
        repeat (4) send(gbn_pkg::MODE_TICK, '0);

        // receiver holds off while every tick brings a full window back
        settle();
        configure(32'd2000000, 32'd64, 32'd1, 32'd255);
        calm         = 1'b1;
        hold_request = 1'b1;
        send(gbn_pkg::MODE_START, '0);
        repeat (6) send(gbn_pkg::MODE_TICK, '0);
        calm = 1'b0;

        mark = tracker.n_acted;
        while (tracker.n_acted - mark < RANDOM_EVENTS) run_transfer();
        settle();

        $display("covered %0d events (%0d acted on) and %0d results", tracker.n_events,
                 tracker.n_acted, tracker.n_results);
        $display({"frames %0d, progress %0d, done %0d, retry failures %0d, ",
                  "cancels %0d, bad chunks %0d"},
                 tracker.kind_seen[gbn_pkg::KIND_FRAME],
                 tracker.kind_seen[gbn_pkg::KIND_PROGRESS],
                 tracker.kind_seen[gbn_pkg::KIND_DONE],
                 tracker.kind_seen[gbn_pkg::KIND_FAIL],
                 tracker.kind_seen[gbn_pkg::KIND_CANCEL],
                 tracker.kind_seen[gbn_pkg::KIND_BADCHUNK]);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
